>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion helpers shared by the rtl
// all checks run on the rising edge of clk_i and are off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> hw/rtl/lhfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhfd_pkg
// Shared types, widths and helpers of the luma histogram frame difference.
// ----------------------------------------------------------------------------
package lhfd_pkg;

  localparam int BINS       = 64;
  localparam int MAX_PIXELS = 4194304;
  localparam int PIX_W      = 8;
  localparam int BIN_W      = $clog2(BINS);
  localparam int PROD_W     = PIX_W + $clog2(BINS + 1);
  localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
  localparam int DIST_W     = $clog2(longint'(BINS) * longint'(MAX_PIXELS) + 1);
  localparam int FRAC_W     = 16;
  localparam int NUM_W      = DIST_W + FRAC_W;
  localparam int RATIO_W    = 18;
  localparam int RATIO_MAX  = 131072;
  localparam int FP_W       = 23;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PIXELS);

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             last_in_frame;
  } lhfd_req_t;

  typedef struct packed {
    logic [RATIO_W-1:0] diff_ratio;
    logic [FP_W-1:0]    frame_pixels;
  } lhfd_res_t;

  // controls from the sequencer to the histogram store
  typedef struct packed {
    logic             pix_valid;
    logic [BIN_W-1:0] pix_bin;
    logic             sweep_valid;
    logic [BIN_W-1:0] sweep_idx;
    logic             swap;
  } lhfd_store_ctrl_t;

  // one bin pair read back during the end-of-frame sweep
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] cur;
    logic [CNT_W-1:0] prev;
  } lhfd_sweep_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v >= CNT_MAX) ? CNT_MAX : v + 1'b1;
  endfunction

endpackage

>>> hw/rtl/lhfd_hist_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhfd_hist_store
// Two bin count banks, current and previous, that swap roles per frame.
// Per-entry valid bits give the cleared value without a clearing pass.
// ----------------------------------------------------------------------------
module lhfd_hist_store import lhfd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lhfd_store_ctrl_t ctrl_i,
  output lhfd_sweep_t      sweep_o
);

  logic [CNT_W-1:0] mem_a [BINS];
  logic [CNT_W-1:0] mem_b [BINS];

  logic             bank_q;
  logic [BINS-1:0]  vld_a_q, vld_b_q;
  logic [BIN_W-1:0] rd_addr;
  logic [CNT_W-1:0] rd_a_q, rd_b_q;
  logic             rd_va_q, rd_vb_q;
  logic             s1_valid_q, sw_valid_q;
  logic [BIN_W-1:0] s1_bin_q;
  logic             fwd_valid_q;
  logic [BIN_W-1:0] fwd_bin_q;
  logic [CNT_W-1:0] fwd_cnt_q;
  logic [CNT_W-1:0] a_val, b_val, cur_val, prev_val, old_cnt, new_cnt;

  assign rd_addr = ctrl_i.pix_valid ? ctrl_i.pix_bin : ctrl_i.sweep_idx;

  always_ff @(posedge clk_i) begin
    rd_a_q <= mem_a[rd_addr];
    rd_b_q <= mem_b[rd_addr];
    if (s1_valid_q && !bank_q) begin
      mem_a[s1_bin_q] <= new_cnt;
    end
    if (s1_valid_q && bank_q) begin
      mem_b[s1_bin_q] <= new_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q      <= 1'b0;
      vld_a_q     <= '0;
      vld_b_q     <= '0;
      rd_va_q     <= 1'b0;
      rd_vb_q     <= 1'b0;
      s1_valid_q  <= 1'b0;
      sw_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      rd_va_q     <= vld_a_q[rd_addr];
      rd_vb_q     <= vld_b_q[rd_addr];
      s1_valid_q  <= ctrl_i.pix_valid;
      sw_valid_q  <= ctrl_i.sweep_valid;
      fwd_valid_q <= s1_valid_q;
      if (ctrl_i.swap) begin
        // the old previous bank becomes current and reads as empty
        bank_q <= ~bank_q;
        if (bank_q) begin
          vld_a_q <= '0;
        end else begin
          vld_b_q <= '0;
        end
      end else if (s1_valid_q) begin
        if (bank_q) begin
          vld_b_q[s1_bin_q] <= 1'b1;
        end else begin
          vld_a_q[s1_bin_q] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_bin_q  <= ctrl_i.pix_bin;
    fwd_bin_q <= s1_bin_q;
    fwd_cnt_q <= new_cnt;
  end

  assign a_val    = rd_va_q ? rd_a_q : '0;
  assign b_val    = rd_vb_q ? rd_b_q : '0;
  assign cur_val  = bank_q ? b_val : a_val;
  assign prev_val = bank_q ? a_val : b_val;

  // the write of the request just before lands on the edge this one was read
  assign old_cnt = (fwd_valid_q && (fwd_bin_q == s1_bin_q)) ? fwd_cnt_q : cur_val;
  assign new_cnt = sat_inc(old_cnt);

  assign sweep_o.valid = sw_valid_q;
  assign sweep_o.cur   = cur_val;
  assign sweep_o.prev  = prev_val;

endmodule

>>> hw/rtl/lhfd_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhfd_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lhfd_divider import lhfd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] numer_i,
  input  logic [CNT_W-1:0] denom_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int STEP_W = $clog2(NUM_W);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W-1:0]  rem_q, rem_d, den_q;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W:0]    trial;
  logic              take;

  // numerator shifts out at the top while quotient bits enter at the bottom
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign take  = trial >= {1'b0, den_q};
  assign rem_d = take ? CNT_W'(trial - {1'b0, den_q}) : CNT_W'(trial);
  assign quo_d = {quo_q[NUM_W-2:0], take};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(NUM_W - 1);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= numer_i;
      rem_q <= '0;
      den_q <= denom_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> hw/rtl/luma_histogram_frame_difference.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luma_histogram_frame_difference
// Per-frame luma histogram and normalised L1 distance to the previous frame.
// ----------------------------------------------------------------------------
// Pixels are taken at one per cycle within a frame; each one is binned into
// a bank of the histogram memory by a read-modify-write with forwarding. The
// request marked last in the frame starts an end-of-frame pass during which
// no pixel is taken: a flush, a sweep over both banks through their single
// read port, a tail, a load, a bit-serial divide of NUM_W steps and a hand-over
// of the result to the output register, held while an earlier result has
// not yet been taken. The banks swap roles at the end of each frame and
// need no clearing pass after reset.
// ----------------------------------------------------------------------------
module luma_histogram_frame_difference import lhfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  input  lhfd_req_t req_i,
  output logic      res_valid_o,
  input  logic      res_ready_i,
  output lhfd_res_t res_o
);

`include "assert_macros.svh"

  typedef enum logic [6:0] {
    ST_PIXEL  = 7'b0000001,
    ST_FLUSH  = 7'b0000010,
    ST_SWEEP  = 7'b0000100,
    ST_TAIL   = 7'b0001000,
    ST_LOAD   = 7'b0010000,
    ST_DIVIDE = 7'b0100000,
    ST_DONE   = 7'b1000000
  } lhfd_state_e;

  lhfd_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q;
  logic [BIN_W-1:0] idx_q;
  logic [DIST_W-1:0] dist_q;
  logic             res_valid_q;
  lhfd_res_t        res_q;

  logic             req_acc, res_load;
  logic [PROD_W-1:0] bin_prod;
  lhfd_store_ctrl_t store_ctrl;
  lhfd_sweep_t      sweep;
  logic [CNT_W-1:0] bin_diff;
  logic [NUM_W-1:0] div_numer, div_quot;
  logic [CNT_W-1:0] div_denom;
  logic             div_done;
  logic [RATIO_W-1:0] ratio;

  assign req_ready_o = (state_q == ST_PIXEL);
  assign req_acc     = req_valid_i && req_ready_o;
  assign res_load    = (state_q == ST_DONE) && (!res_valid_q || res_ready_i);

  assign bin_prod = PROD_W'(req_i.pixel_value) * PROD_W'(BINS);

  always_comb begin
    store_ctrl.pix_valid   = req_acc;
    store_ctrl.pix_bin     = BIN_W'(bin_prod >> PIX_W);
    store_ctrl.sweep_valid = (state_q == ST_SWEEP);
    store_ctrl.sweep_idx   = idx_q;
    store_ctrl.swap        = res_load;
  end

  lhfd_hist_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (store_ctrl),
    .sweep_o (sweep)
  );

  assign bin_diff = (sweep.cur >= sweep.prev) ? sweep.cur - sweep.prev
                                              : sweep.prev - sweep.cur;

  // distance in Q.16 plus half the divisor for round to nearest
  assign div_numer = {dist_q, FRAC_W'(0)} + NUM_W'(cnt_q >> 1);
  assign div_denom = (cnt_q == '0) ? CNT_W'(1) : cnt_q;

  lhfd_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_LOAD),
    .numer_i (div_numer),
    .denom_i (div_denom),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign ratio = (div_quot > NUM_W'(RATIO_MAX)) ? RATIO_W'(RATIO_MAX) : RATIO_W'(div_quot);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_PIXEL: begin
        if (req_acc && req_i.last_in_frame) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: state_d = ST_SWEEP;
      ST_SWEEP: begin
        if (idx_q == BIN_W'(BINS - 1)) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL:  state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_DIVIDE;
      ST_DIVIDE: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_load) begin
          state_d = ST_PIXEL;
        end
      end
      default: state_d = ST_PIXEL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_PIXEL;
      cnt_q       <= '0;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_load) begin
        cnt_q <= '0;
      end else if (req_acc) begin
        cnt_q <= sat_inc(cnt_q);
      end
      if (state_q == ST_SWEEP) begin
        idx_q <= idx_q + 1'b1;
      end else begin
        idx_q <= '0;
      end
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FLUSH) begin
      dist_q <= '0;
    end else if (sweep.valid) begin
      dist_q <= dist_q + DIST_W'(bin_diff);
    end
    if (res_load) begin
      res_q.diff_ratio   <= ratio;
      res_q.frame_pixels <= FP_W'(cnt_q);
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `ASSERT_HOLDS(a_res_from_done, $rose(res_valid_q) |-> $past(state_q == ST_DONE), "result without finished frame")
  `ASSERT_NEVER(a_div_done_stray, div_done && (state_q != ST_DIVIDE), "divider done outside divide")
  `ASSERT_HOLDS(a_cnt_sat, cnt_q <= CNT_MAX, "pixel counter above saturation")
  `ASSERT_NEVER(a_sweep_overlap, sweep.valid && $past(req_acc), "sweep read overlaps pixel update")

endmodule

>>> tb/sv/luma_histogram_frame_difference_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luma_histogram_frame_difference_tb
// Streams frames of luma pixels through the block under random idling on both
// handshakes and checks every per-frame difference ratio and pixel count
// against a histogram predictor kept in the testbench.
// ----------------------------------------------------------------------------
module luma_histogram_frame_difference_tb;
  import lhfd_pkg::*;

  localparam int unsigned RATIO_UNIT   = 65536;
  localparam int unsigned PIXEL_TARGET = 950;
  localparam int unsigned QUIET_FROM   = 850;
  localparam int unsigned FRAME_TARGET = 40;
  localparam int unsigned SETTLE_CYCLES = 160;

  typedef enum int {
    SCENE_NOISE,
    SCENE_NEAR,
    SCENE_REPEAT,
    SCENE_FLAT
  } scene_e;

  // histogram predictor and store of outstanding frame results
  class frame_diff_scoreboard;
    int unsigned     cur_bins[BINS];
    int unsigned     prev_bins[BINS];
    int unsigned     pix_count;
    lhfd_res_t       pending_frames[$];
    int unsigned     pixels_seen;
    int unsigned     frames_checked;
    int unsigned     mismatches;

    function new();
      foreach (cur_bins[i]) begin
        cur_bins[i]  = 0;
        prev_bins[i] = 0;
      end
      pix_count      = 0;
      pixels_seen    = 0;
      frames_checked = 0;
      mismatches     = 0;
    endfunction

    function void note_pixel(lhfd_req_t r);
      int unsigned     bin;
      longint unsigned l1_sum;
      longint unsigned ratio;
      longint unsigned divisor;
      lhfd_res_t       want;
      pixels_seen++;
      bin = (int'(r.pixel_value) * BINS) >> PIX_W;
      if (bin >= BINS) bin = BINS - 1;
      if (cur_bins[bin] < MAX_PIXELS) cur_bins[bin]++;
      if (pix_count < MAX_PIXELS) pix_count++;
      if (!r.last_in_frame) return;
      l1_sum = 0;
      foreach (cur_bins[i]) begin
        if (cur_bins[i] >= prev_bins[i]) l1_sum += cur_bins[i] - prev_bins[i];
        else l1_sum += prev_bins[i] - cur_bins[i];
      end
      divisor = (pix_count == 0) ? 1 : pix_count;
      // round to nearest, halves up
      ratio = (l1_sum * RATIO_UNIT + divisor / 2) / divisor;
      if (ratio > RATIO_MAX) ratio = RATIO_MAX;
      want.diff_ratio   = RATIO_W'(ratio);
      want.frame_pixels = FP_W'(pix_count);
      pending_frames.push_back(want);
      foreach (cur_bins[i]) begin
        prev_bins[i] = cur_bins[i];
        cur_bins[i]  = 0;
      end
      pix_count = 0;
    endfunction

    function void flag(string what, longint unsigned want_v, longint unsigned got_v);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %0d: %s expected %0d got %0d", mismatches, what, want_v, got_v);
    endfunction

    function void check_result(lhfd_res_t got);
      lhfd_res_t want;
      if (pending_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch %0d: result with no frame outstanding, diff_ratio %0d frame_pixels %0d",
                   mismatches, got.diff_ratio, got.frame_pixels);
        return;
      end
      want = pending_frames.pop_front();
      frames_checked++;
      if (got.diff_ratio !== want.diff_ratio)
        flag("diff_ratio", want.diff_ratio, got.diff_ratio);
      if (got.frame_pixels !== want.frame_pixels)
        flag("frame_pixels", want.frame_pixels, got.frame_pixels);
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      req_valid_i;
  logic      req_ready_o;
  lhfd_req_t req_i;
  logic      res_valid_o;
  logic      res_ready_i;
  lhfd_res_t res_o;

  frame_diff_scoreboard sb = new();
  bit          tx_idle_on;
  bit          rx_stall_on;
  int unsigned frames_sent;

  luma_histogram_frame_difference u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_ready_i (res_ready_i),
    .res_o       (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("luma_histogram_frame_difference regression: fail");
    $finish;
  end

  // result side: random stall bursts on ready
  initial begin
    int unsigned stall_left;
    stall_left  = 0;
    res_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_stall_on && stall_left == 0 && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 14);
      if (stall_left > 0) begin
        res_ready_i = 1'b0;
        stall_left--;
      end else begin
        res_ready_i = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o && res_ready_i) sb.check_result(res_o);
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic last);
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      req_valid_i = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    req_valid_i         = 1'b1;
    req_i.pixel_value   = pix;
    req_i.last_in_frame = last;
    do @(posedge clk_i); while (!req_ready_o);
    sb.note_pixel(req_i);
    if (last) frames_sent++;
    @(negedge clk_i);
  endtask

  // the request just taken must not be offered again while waiting
  task automatic wait_all_results();
    req_valid_i = 1'b0;
    while (sb.pending_frames.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [PIX_W-1:0] bin_edges_a[8];
    logic [PIX_W-1:0] bin_edges_b[8];
    logic [PIX_W-1:0] prev_scene[$];
    logic [PIX_W-1:0] this_scene[$];
    logic [PIX_W-1:0] pix;
    scene_e           scene;
    int unsigned      len;
    int               base;
    int               near;
    bit               drained_mid;

    bin_edges_a = '{8'd63, 8'd64, 8'd127, 8'd128, 8'd191, 8'd192, 8'd85, 8'd170};
    bin_edges_b = '{8'd60, 8'd65, 8'd124, 8'd129, 8'd188, 8'd195, 8'd87, 8'd168};
    rst_ni      = 1'b0;
    req_valid_i = 1'b0;
    req_i       = '0;
    tx_idle_on  = 1'b1;
    rx_stall_on = 1'b1;
    frames_sent = 0;
    drained_mid = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // both stores start empty, so a lone pixel reads as 1.0
    send_pixel(8'd0, 1'b1);
    // bottom bin to top bin: the largest ratio, equal to the saturation value
    send_pixel(8'd255, 1'b1);
    // same top bin again: no change
    send_pixel(8'd252, 1'b1);
    // two thirds, rounded to nearest
    send_pixel(8'd3, 1'b0);
    send_pixel(8'd4, 1'b0);
    send_pixel(8'd255, 1'b1);
    // pixels either side of bin boundaries, then the same bins reached differently
    foreach (bin_edges_a[i]) send_pixel(bin_edges_a[i], i == 7);
    foreach (bin_edges_b[i]) send_pixel(bin_edges_b[i], i == 7);

    // hold off the next request until every frame has been reported
    wait_all_results();

    while (sb.pixels_seen < PIXEL_TARGET || frames_sent < FRAME_TARGET) begin
      if (sb.pixels_seen >= QUIET_FROM) begin
        tx_idle_on  = 1'b0;
        rx_stall_on = 1'b0;
      end else begin
        tx_idle_on  = ($urandom_range(0, 3) != 0);
        rx_stall_on = ($urandom_range(0, 3) != 0);
      end
      if (!drained_mid && frames_sent >= 20) begin
        wait_all_results();
        drained_mid = 1'b1;
      end
      // mostly short frames so that results come often, a few long ones
      len   = ($urandom_range(0, 11) == 0) ? $urandom_range(64, 160) : $urandom_range(1, 24);
      scene = scene_e'($urandom_range(0, 3));
      base  = $urandom_range(0, 255);
      this_scene.delete();
      for (int unsigned i = 0; i < len; i++) begin
        case (scene)
          SCENE_NEAR: begin
            near = base + $urandom_range(0, 16) - 8;
            if (near < 0) near = 0;
            if (near > 255) near = 255;
            pix = PIX_W'(near);
          end
          SCENE_REPEAT: begin
            // resample the previous frame: a near-identical histogram
            if (prev_scene.size() != 0)
              pix = prev_scene[$urandom_range(0, prev_scene.size() - 1)];
            else
              pix = PIX_W'($urandom_range(0, 255));
          end
          SCENE_FLAT: begin
            pix = PIX_W'(base);
          end
          default: begin
            pix = PIX_W'($urandom_range(0, 255));
          end
        endcase
        this_scene.push_back(pix);
        send_pixel(pix, i == len - 1);
      end
      prev_scene = this_scene;
    end
    req_valid_i = 1'b0;

    wait_all_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (sb.pending_frames.size() != 0) begin
      $display("%0d frame results never arrived", sb.pending_frames.size());
      sb.mismatches += sb.pending_frames.size();
    end

    $display("streamed %0d pixels in %0d frames, %0d frame results compared, %0d mismatches",
             sb.pixels_seen, frames_sent, sb.frames_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("luma_histogram_frame_difference regression: pass");
    end else begin
      $display("luma_histogram_frame_difference regression: fail");
    end
    $finish;
  end

endmodule
